FILE: design/assist_torque_mode_sequencer_defines.svh
// ---------------------------------------------------------------------------
// Assist torque mode sequencer: assertion macros
// Assertion forms for the sequencer's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef ASSIST_TORQUE_MODE_SEQUENCER_DEFINES_SVH
`define ASSIST_TORQUE_MODE_SEQUENCER_DEFINES_SVH

// Property checked on every clock edge while out of reset.
`define ATMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define ATMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/atms_pkg.sv
// ---------------------------------------------------------------------------
// Assist torque mode sequencer package
// Fixed-point constants, mode and register codes, and shared types.
// ---------------------------------------------------------------------------
package atms_pkg;

    // Fixed-point format of the torque scale and width of the anchor counter.
    localparam int SCALE_FRAC_BITS   = 15;
    localparam int ANCHOR_COUNT_BITS = 8;

    localparam int SCALE_W  = SCALE_FRAC_BITS + 1;
    localparam int TORQUE_W = 16;
    localparam int CONF_W   = 16;
    localparam int TIME_W   = 16;
    localparam int WARMUP_W = 8;
    localparam int RATE_W   = 20;
    localparam int RATE_SHIFT = 20;
    localparam int PROD_W   = RATE_W + TIME_W;
    localparam int MODE_W   = 3;

    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    // One, and the threshold for active mode, round(0.999 * one).
    localparam longint unsigned SCALE_ONE_L    = 64'd1 << SCALE_FRAC_BITS;
    localparam longint unsigned SCALE_ACTIVE_L = (SCALE_ONE_L * 999 + 500) / 1000;
    localparam logic [SCALE_W-1:0] SCALE_ONE    = SCALE_W'(SCALE_ONE_L);
    localparam logic [SCALE_W-1:0] SCALE_ACTIVE = SCALE_W'(SCALE_ACTIVE_L);

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_TRANSPARENT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRACKING    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RAMP        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ACTIVE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOPPING    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FROZEN      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FAULT       = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_CONF = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXIT_CONF  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WARMUP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_UP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_DOWN  = 3'd4;

    // Configuration reset values.
    localparam logic [CONF_W-1:0]   ENTRY_CONF_RST = 16'd39321;
    localparam logic [CONF_W-1:0]   EXIT_CONF_RST  = 16'd26214;
    localparam logic [WARMUP_W-1:0] WARMUP_RST     = 8'd3;
    localparam logic [RATE_W-1:0]   RAMP_UP_RST    = 20'd32768;
    localparam logic [RATE_W-1:0]   RAMP_DOWN_RST  = 20'd32768;

    typedef struct packed {
        logic [CONF_W-1:0]   entry_confidence;
        logic [CONF_W-1:0]   exit_confidence;
        logic [WARMUP_W-1:0] warmup_anchors;
        logic [RATE_W-1:0]   ramp_up_rate;
        logic [RATE_W-1:0]   ramp_down_rate;
    } atms_cfg_t;

    typedef struct packed {
        logic              fault_flag;
        logic              freeze_request;
        logic              stop_request;
        logic [CONF_W-1:0] gait_confidence;
        logic              phase_ok;
        logic              anchor_seen;
        logic [TIME_W-1:0] tick_time;
    } atms_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic [SCALE_W-1:0]           scale;
        logic [ANCHOR_COUNT_BITS-1:0] anchor_count;
    } atms_state_t;

endpackage

FILE: design/atms_item_if.sv
// ---------------------------------------------------------------------------
// Sequencer tick channel
// Valid/ready channel that carries one control tick's inputs.
// ---------------------------------------------------------------------------
interface atms_item_if
    import atms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              fault_flag;
    logic              freeze_request;
    logic              stop_request;
    logic [CONF_W-1:0] gait_confidence;
    logic              phase_ok;
    logic              anchor_seen;
    logic [TIME_W-1:0] tick_time;

    modport source (
        output valid, fault_flag, freeze_request, stop_request,
               gait_confidence, phase_ok, anchor_seen, tick_time,
        input  ready
    );

    modport sink (
        input  valid, fault_flag, freeze_request, stop_request,
               gait_confidence, phase_ok, anchor_seen, tick_time,
        output ready
    );
endinterface

FILE: design/atms_result_if.sv
// ---------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel that carries the mode, torque scale and drive enable.
// ---------------------------------------------------------------------------
interface atms_result_if
    import atms_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [TORQUE_W-1:0] torque_level;
    logic                drive_enable;

    modport source (
        output valid, mode, torque_level, drive_enable,
        input  ready
    );

    modport sink (
        input  valid, mode, torque_level, drive_enable,
        output ready
    );
endinterface

FILE: design/atms_cfg_regs.sv
// ---------------------------------------------------------------------------
// Sequencer configuration registers
// Write-only register file for thresholds, warm-up count and ramp rates.
// ---------------------------------------------------------------------------
module atms_cfg_regs
    import atms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output atms_cfg_t              cfg
);

    atms_cfg_t cfg_reg;
    atms_cfg_t cfg_next;

    // Decode the write; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENTRY_CONF: cfg_next.entry_confidence = cfg_data[CONF_W-1:0];
                REG_EXIT_CONF:  cfg_next.exit_confidence  = cfg_data[CONF_W-1:0];
                REG_WARMUP:     cfg_next.warmup_anchors   = cfg_data[WARMUP_W-1:0];
                REG_RAMP_UP:    cfg_next.ramp_up_rate     = cfg_data[RATE_W-1:0];
                REG_RAMP_DOWN:  cfg_next.ramp_down_rate   = cfg_data[RATE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_confidence <= ENTRY_CONF_RST;
            cfg_reg.exit_confidence  <= EXIT_CONF_RST;
            cfg_reg.warmup_anchors   <= WARMUP_RST;
            cfg_reg.ramp_up_rate     <= RAMP_UP_RST;
            cfg_reg.ramp_down_rate   <= RAMP_DOWN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/atms_step.sv
// ---------------------------------------------------------------------------
// Sequencer step logic
// Next mode, torque scale and anchor count for one tick, with the shared
// ramp multiplier.
// ---------------------------------------------------------------------------
module atms_step
    import atms_pkg::*;
(
    input  atms_item_t  item,
    input  atms_state_t state,
    input  atms_cfg_t   cfg,
    output atms_state_t next
);

    localparam logic [ANCHOR_COUNT_BITS-1:0] ANCHOR_MAX = '1;

    logic [RATE_W-1:0]  rate;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  shifted;
    logic [SCALE_W-1:0] step;
    logic [SCALE_W:0]   ramp_sum;
    logic [SCALE_W-1:0] ramp_scale;
    logic [ANCHOR_COUNT_BITS-1:0] count_inc;
    logic               lost;
    logic               entered;

    // One multiplier serves both ramps: stop selects the down rate.
    assign rate    = item.stop_request ? cfg.ramp_down_rate : cfg.ramp_up_rate;
    assign product = PROD_W'(rate) * PROD_W'(item.tick_time);
    assign shifted = product >> RATE_SHIFT;
    assign step    = (shifted > PROD_W'(SCALE_ONE)) ? SCALE_ONE : SCALE_W'(shifted);

    // Ramp-up sum, clamped to one.
    assign ramp_sum   = (SCALE_W + 1)'(state.scale) + (SCALE_W + 1)'(step);
    assign ramp_scale = (ramp_sum > (SCALE_W + 1)'(SCALE_ONE)) ? SCALE_ONE
                                                               : SCALE_W'(ramp_sum);

    // Confidence hysteresis.
    assign lost    = (item.gait_confidence < cfg.exit_confidence) || !item.phase_ok;
    assign entered = (item.gait_confidence >= cfg.entry_confidence) && item.phase_ok;

    // Saturating anchor count.
    assign count_inc = (state.anchor_count < ANCHOR_MAX)
                       ? state.anchor_count + ANCHOR_COUNT_BITS'(1)
                       : state.anchor_count;

    // Flags in priority order, then the mode sequencer.
    always_comb
    begin
        next = state;
        if (item.fault_flag)
        begin
            next.mode  = MODE_FAULT;
            next.scale = '0;
        end
        else if (item.freeze_request)
        begin
            next.mode         = MODE_FROZEN;
            next.scale        = '0;
            next.anchor_count = '0;
        end
        else if (item.stop_request)
        begin
            next.mode  = MODE_STOPPING;
            next.scale = (state.scale > step) ? state.scale - step : '0;
        end
        else
        begin
            case (state.mode)
                MODE_TRANSPARENT:
                begin
                    next.scale        = '0;
                    next.anchor_count = '0;
                    if (entered)
                        next.mode = MODE_TRACKING;
                end
                MODE_TRACKING:
                begin
                    next.scale = '0;
                    if (lost)
                    begin
                        next.mode         = MODE_TRANSPARENT;
                        next.anchor_count = '0;
                    end
                    else if (item.anchor_seen)
                    begin
                        next.anchor_count = count_inc;
                        if (32'(count_inc) >= 32'(cfg.warmup_anchors))
                            next.mode = MODE_RAMP;
                    end
                end
                MODE_RAMP:
                begin
                    if (lost)
                    begin
                        next.mode         = MODE_TRANSPARENT;
                        next.scale        = '0;
                        next.anchor_count = '0;
                    end
                    else
                    begin
                        next.scale = ramp_scale;
                        if (ramp_scale >= SCALE_ACTIVE)
                            next.mode = MODE_ACTIVE;
                    end
                end
                MODE_ACTIVE:
                begin
                    if (lost)
                    begin
                        next.mode         = MODE_TRANSPARENT;
                        next.scale        = '0;
                        next.anchor_count = '0;
                    end
                    else
                    begin
                        next.scale = SCALE_ONE;
                    end
                end
                MODE_STOPPING, MODE_FROZEN:
                begin
                    next.mode         = MODE_TRACKING;
                    next.scale        = '0;
                    next.anchor_count = '0;
                end
                default:
                begin
                    next = state;
                end
            endcase
        end
    end

endmodule

FILE: design/assist_torque_mode_sequencer.sv
// ---------------------------------------------------------------------------
// Assist torque mode sequencer
// Seven-mode assist sequencer with hysteresis, anchor warm-up and a ramped
// Q1.15 torque scale; one result word for every tick word.
// ---------------------------------------------------------------------------
//
//   Channel     Direction  Contents
//   item_in     sink       fault, freeze, stop, confidence, phase, anchor, time
//   result_out  source     mode, torque_level, drive_enable
//   cfg_*       write      thresholds, warm-up anchors, ramp rates
//
// A word is registered on entry, and its result is computed from the entry
// register and the mode state into the result register, so the entry and
// result registers lie between a tick word and its result word; one word
// per cycle is sustained while the result side is ready. The mode state
// feeds back through its own register alone, which sets the rate.
// Reset clears the mode to transparent, the scale and anchor count to zero
// and loads the register defaults. A stalled result holds its register;
// the entry register still takes one more word behind it.
//
`include "assist_torque_mode_sequencer_defines.svh"

module assist_torque_mode_sequencer
    import atms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    atms_item_if.sink              item_in,
    atms_result_if.source          result_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    atms_cfg_t   cfg;
    atms_item_t  item_reg;
    atms_item_t  item_next;
    logic        item_valid_reg;
    logic        item_valid_next;
    atms_state_t state_reg;
    atms_state_t state_next;
    atms_state_t step_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        drive_reg;
    logic        drive_next;
    logic        advance;
    logic        fire;
    logic        take;

    // Configuration registers.
    atms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Next-state logic for the word in the entry register.
    atms_step u_step (
        .item  (item_reg),
        .state (state_reg),
        .cfg   (cfg),
        .next  (step_next)
    );

    // Handshake: the result register frees when empty or being read.
    assign advance       = !out_valid_reg || result_out.ready;
    assign fire          = item_valid_reg && advance;
    assign item_in.ready = !item_valid_reg || advance;
    assign take          = item_in.valid && item_in.ready;

    // Entry register.
    always_comb
    begin
        item_next.fault_flag      = item_in.fault_flag;
        item_next.freeze_request  = item_in.freeze_request;
        item_next.stop_request    = item_in.stop_request;
        item_next.gait_confidence = item_in.gait_confidence;
        item_next.phase_ok        = item_in.phase_ok;
        item_next.anchor_seen     = item_in.anchor_seen;
        item_next.tick_time       = item_in.tick_time;
        if (take)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    // Mode state and result register update together when a word is processed.
    always_comb
    begin
        state_next = fire ? step_next : state_reg;
        drive_next = ((step_next.mode == MODE_RAMP) || (step_next.mode == MODE_ACTIVE) ||
                      (step_next.mode == MODE_STOPPING)) && (step_next.scale != '0);
        if (fire)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg         <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.mode         <= MODE_TRANSPARENT;
            state_reg.scale        <= '0;
            state_reg.anchor_count <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
        if (fire)
            drive_reg <= drive_next;
    end

    // The result shows the state left by the last processed word.
    assign result_out.valid        = out_valid_reg;
    assign result_out.mode         = state_reg.mode;
    assign result_out.torque_level = TORQUE_W'(state_reg.scale);
    assign result_out.drive_enable = drive_reg;

    // Assertions.
    `ATMS_ASSERT(a_scale_bounded, state_reg.scale <= SCALE_ONE, "torque scale above one")
    `ATMS_ASSERT(a_state_holds, !fire |=> $stable(state_reg), "state moved without a word")
    `ATMS_ASSERT(a_zero_scale_modes,
        ((state_reg.mode == MODE_TRANSPARENT) || (state_reg.mode == MODE_TRACKING) ||
         (state_reg.mode == MODE_FROZEN) || (state_reg.mode == MODE_FAULT))
        |-> (state_reg.scale == '0), "nonzero scale in a zero-torque mode")
    `ATMS_ASSERT(a_drive_needs_scale,
        (out_valid_reg && drive_reg) |-> (state_reg.scale != '0),
        "drive enabled with zero scale")
    `ATMS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!item_valid_reg && !out_valid_reg),
        "pipeline busy during reset")

endmodule

FILE: sim/assist_torque_mode_sequencer_test.sv
// ---------------------------------------------------------------------------
// Assist torque mode sequencer testbench
// Drives control tick words into the sequencer through its valid/ready
// channels and compares each result word, field by field, with an
// independent cycle-free model of the mode, scale and anchor state. The run
// goes through a directed sequence and then several register settings with
// mostly well-formed gait sequences, with random idling on both sides.
// ---------------------------------------------------------------------------
module assist_torque_mode_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atms_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [TORQUE_W-1:0] torque_level;
        logic                drive_enable;
    } tick_result_t;

    // Tracks the sequencer state and holds the result words still owed.
    class torque_scoreboard;
        atms_cfg_t                    cfg;
        logic [MODE_W-1:0]            mode_q;
        logic [SCALE_W-1:0]           scale_q;
        logic [ANCHOR_COUNT_BITS-1:0] anchors_q;
        tick_result_t                 expected_q[$];
        int                           errors;
        int                           checked;

        function new();
            cfg.entry_confidence = ENTRY_CONF_RST;
            cfg.exit_confidence  = EXIT_CONF_RST;
            cfg.warmup_anchors   = WARMUP_RST;
            cfg.ramp_up_rate     = RAMP_UP_RST;
            cfg.ramp_down_rate   = RAMP_DOWN_RST;
            mode_q    = MODE_TRANSPARENT;
            scale_q   = '0;
            anchors_q = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_ENTRY_CONF: cfg.entry_confidence = data[CONF_W-1:0];
                REG_EXIT_CONF:  cfg.exit_confidence  = data[CONF_W-1:0];
                REG_WARMUP:     cfg.warmup_anchors   = data[WARMUP_W-1:0];
                REG_RAMP_UP:    cfg.ramp_up_rate     = data[RATE_W-1:0];
                REG_RAMP_DOWN:  cfg.ramp_down_rate   = data[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        // Scale change for one tick: rate times elapsed time, truncated, capped at one.
        function logic [SCALE_W-1:0] ramp_delta(logic [RATE_W-1:0] rate,
                                                logic [TIME_W-1:0] dt);
            logic [PROD_W-1:0] delta;
            delta = (PROD_W'(rate) * PROD_W'(dt)) >> RATE_SHIFT;
            if (delta > PROD_W'(SCALE_ONE))
                delta = PROD_W'(SCALE_ONE);
            return delta[SCALE_W-1:0];
        endfunction

        function void drop_assist();
            mode_q    = MODE_TRANSPARENT;
            scale_q   = '0;
            anchors_q = '0;
        endfunction

        // Advances the state by one accepted tick word and queues its result.
        function void note_tick(atms_item_t t);
            logic               lost;
            logic [SCALE_W-1:0] delta;
            logic [SCALE_W:0]   sum;
            tick_result_t       want;
            lost = (t.gait_confidence < cfg.exit_confidence) || !t.phase_ok;
            if (t.fault_flag)
            begin
                mode_q  = MODE_FAULT;
                scale_q = '0;
            end
            else if (t.freeze_request)
            begin
                mode_q    = MODE_FROZEN;
                scale_q   = '0;
                anchors_q = '0;
            end
            else if (t.stop_request)
            begin
                delta   = ramp_delta(cfg.ramp_down_rate, t.tick_time);
                mode_q  = MODE_STOPPING;
                scale_q = (scale_q > delta) ? scale_q - delta : '0;
            end
            else
            begin
                case (mode_q)
                    MODE_TRANSPARENT:
                    begin
                        scale_q   = '0;
                        anchors_q = '0;
                        if (t.gait_confidence >= cfg.entry_confidence && t.phase_ok)
                            mode_q = MODE_TRACKING;
                    end
                    MODE_TRACKING:
                    begin
                        scale_q = '0;
                        if (lost)
                            drop_assist();
                        else if (t.anchor_seen)
                        begin
                            if (anchors_q != '1)
                                anchors_q++;
                            if (anchors_q >= cfg.warmup_anchors)
                                mode_q = MODE_RAMP;
                        end
                    end
                    MODE_RAMP:
                    begin
                        if (lost)
                            drop_assist();
                        else
                        begin
                            sum = (SCALE_W + 1)'(scale_q)
                                  + (SCALE_W + 1)'(ramp_delta(cfg.ramp_up_rate, t.tick_time));
                            if (sum > (SCALE_W + 1)'(SCALE_ONE))
                                sum = (SCALE_W + 1)'(SCALE_ONE);
                            scale_q = sum[SCALE_W-1:0];
                            if (scale_q >= SCALE_ACTIVE)
                                mode_q = MODE_ACTIVE;
                        end
                    end
                    MODE_ACTIVE:
                    begin
                        if (lost)
                            drop_assist();
                        else
                            scale_q = SCALE_ONE;
                    end
                    MODE_STOPPING, MODE_FROZEN:
                    begin
                        mode_q    = MODE_TRACKING;
                        scale_q   = '0;
                        anchors_q = '0;
                    end
                    default: ;
                endcase
            end
            want.mode         = mode_q;
            want.torque_level = TORQUE_W'(scale_q);
            want.drive_enable = (mode_q inside {MODE_RAMP, MODE_ACTIVE, MODE_STOPPING})
                                && (scale_q != '0);
            expected_q.push_back(want);
        endfunction

        // Compares one result word with the oldest one owed.
        function void check_result(tick_result_t got);
            tick_result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                note_error($sformatf("result word %0d with none owed: mode %0d torque %0d en %0b",
                                     checked, got.mode, got.torque_level, got.drive_enable));
                return;
            end
            want = expected_q.pop_front();
            if (got.mode !== want.mode || got.torque_level !== want.torque_level
                || got.drive_enable !== want.drive_enable)
                note_error($sformatf({"result word %0d: mode exp %0d got %0d, ",
                                      "torque exp %0d got %0d, enable exp %0b got %0b"},
                                     checked, want.mode, got.mode, want.torque_level,
                                     got.torque_level, want.drive_enable, got.drive_enable));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   calm = 1'b0;
    int                     cycle_count;

    torque_scoreboard sb = new();

    atms_item_if   item_ch();
    atms_result_if result_ch();

    assist_torque_mode_sequencer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Cycle counter that stops a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: ready with random stall bursts, none in the calm part.
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Every accepted result word is checked at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(tick_result_t'{result_ch.mode, result_ch.torque_level,
                                           result_ch.drive_enable});
    end

    function automatic atms_item_t tick_word(int fault, int freeze, int stop,
                                             logic [CONF_W-1:0] conf, int phase,
                                             int anchor, logic [TIME_W-1:0] dt);
        atms_item_t t;
        t.fault_flag      = 1'(fault);
        t.freeze_request  = 1'(freeze);
        t.stop_request    = 1'(stop);
        t.gait_confidence = conf;
        t.phase_ok        = 1'(phase);
        t.anchor_seen     = 1'(anchor);
        t.tick_time       = dt;
        return t;
    endfunction

    // Mostly well-formed gait ticks; a share of fully random noise words.
    function automatic atms_item_t make_tick(int anchor_pct, int noise_pct);
        atms_item_t t;
        int         lo;
        t  = '0;
        lo = (sb.cfg.entry_confidence > sb.cfg.exit_confidence) ?
             int'(sb.cfg.entry_confidence) : int'(sb.cfg.exit_confidence);
        if ($urandom_range(0, 99) < noise_pct)
        begin
            t.fault_flag      = ($urandom_range(0, 3) == 0);
            t.freeze_request  = 1'($urandom_range(0, 1));
            t.stop_request    = 1'($urandom_range(0, 1));
            t.gait_confidence = CONF_W'($urandom_range(0, 65535));
            t.phase_ok        = 1'($urandom_range(0, 1));
            t.anchor_seen     = 1'($urandom_range(0, 1));
            t.tick_time       = TIME_W'($urandom_range(0, 65535));
        end
        else
        begin
            t.stop_request    = ($urandom_range(0, 199) < noise_pct);
            t.gait_confidence = CONF_W'($urandom_range(65535, lo));
            t.phase_ok        = 1'b1;
            t.anchor_seen     = ($urandom_range(0, 99) < anchor_pct);
            t.tick_time       = ($urandom_range(0, 2) == 0) ? TIME_W'($urandom_range(0, 2047))
                                                            : TIME_W'($urandom_range(0, 65535));
        end
        return t;
    endfunction

    function automatic atms_cfg_t random_config();
        atms_cfg_t c;
        c.entry_confidence = CONF_W'($urandom_range(0, 65535));
        c.exit_confidence  = ($urandom_range(0, 4) == 0)
                             ? CONF_W'($urandom_range(0, 65535))
                             : CONF_W'($urandom_range(0, c.entry_confidence));
        c.warmup_anchors   = WARMUP_W'($urandom_range(0, 6));
        c.ramp_up_rate     = RATE_W'($urandom_range(1 << 12, 1 << 18));
        c.ramp_down_rate   = RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
        return c;
    endfunction

    // Offers one tick word, with an occasional idle burst first.
    task automatic send_tick(atms_item_t t);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.fault_flag      <= t.fault_flag;
        item_ch.freeze_request  <= t.freeze_request;
        item_ch.stop_request    <= t.stop_request;
        item_ch.gait_confidence <= t.gait_confidence;
        item_ch.phase_ok        <= t.phase_ok;
        item_ch.anchor_seen     <= t.anchor_seen;
        item_ch.tick_time       <= t.tick_time;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_tick(t);
    endtask

    // Waits until every owed result word has come and the pipeline is empty.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers on consecutive cycles.
    task automatic write_config(atms_cfg_t c);
        logic [CFG_INDEX_W-1:0] index_list [5] = '{REG_ENTRY_CONF, REG_EXIT_CONF, REG_WARMUP,
                                                   REG_RAMP_UP, REG_RAMP_DOWN};
        logic [CFG_DATA_W-1:0]  data_list  [5];
        data_list = '{CFG_DATA_W'(c.entry_confidence), CFG_DATA_W'(c.exit_confidence),
                      CFG_DATA_W'(c.warmup_anchors), CFG_DATA_W'(c.ramp_up_rate),
                      CFG_DATA_W'(c.ramp_down_rate)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= index_list[i];
            cfg_data  <= data_list[i];
            @(posedge clk);
            sb.write_reg(index_list[i], data_list[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(atms_cfg_t c, int count, int anchor_pct, int noise_pct);
        wait_drained();
        write_config(c);
        for (int n = 0; n < count; n++)
            send_tick(make_tick(anchor_pct, noise_pct));
    endtask

    // Main sequence: reset, directed ticks, then random phases.
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = REG_ENTRY_CONF;
        cfg_data                = '0;
        item_ch.valid           = 1'b0;
        item_ch.fault_flag      = 1'b0;
        item_ch.freeze_request  = 1'b0;
        item_ch.stop_request    = 1'b0;
        item_ch.gait_confidence = '0;
        item_ch.phase_ok        = 1'b0;
        item_ch.anchor_seen     = 1'b0;
        item_ch.tick_time       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fast ramp up so the active threshold is hit exactly.
        write_config('{ENTRY_CONF_RST, EXIT_CONF_RST, WARMUP_RST, 20'hFFFFF, RAMP_DOWN_RST});
        send_tick(tick_word(0, 0, 0, 16'd0,     0, 0, 16'd0));
        send_tick(tick_word(0, 0, 0, 16'd39320, 1, 1, 16'hFFFF));
        send_tick(tick_word(0, 0, 0, 16'd39321, 1, 0, 16'd0));
        // Confidence right at the exit threshold still counts as held.
        send_tick(tick_word(0, 0, 0, 16'd26214, 1, 1, 16'd100));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 1, 16'd100));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd100));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 1, 16'd100));
        // Ramp to one short of the active threshold, then onto it.
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd32000));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd736));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd2));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd0));
        // Flag priority: stop, freeze over stop, fault over all, sticky fault.
        send_tick(tick_word(0, 0, 1, 16'hFFFF,  1, 0, 16'hFFFF));
        send_tick(tick_word(0, 1, 1, 16'hFFFF,  1, 0, 16'hFFFF));
        send_tick(tick_word(1, 1, 0, 16'hFFFF,  1, 1, 16'hFFFF));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 1, 16'hFFFF));
        send_tick(tick_word(1, 1, 1, 16'hFFFF,  1, 1, 16'hFFFF));
        send_tick(tick_word(0, 0, 1, 16'hFFFF,  1, 0, 16'hFFFF));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd0));
        // Loss of phase and confidence just below exit drop to transparent.
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  0, 1, 16'd0));
        send_tick(tick_word(0, 0, 0, 16'hFFFF,  1, 0, 16'd0));
        send_tick(tick_word(0, 0, 0, 16'd26213, 1, 1, 16'd0));
        // Fault left through freeze, then frozen back to tracking.
        send_tick(tick_word(1, 0, 0, 16'd0,     0, 0, 16'd0));
        send_tick(tick_word(0, 1, 0, 16'd0,     0, 0, 16'd0));
        send_tick(tick_word(0, 0, 0, 16'd0,     0, 0, 16'd0));

        // Random phases: defaults, low extremes, high extremes, random settings.
        run_phase('{ENTRY_CONF_RST, EXIT_CONF_RST, WARMUP_RST, RAMP_UP_RST, RAMP_DOWN_RST},
                  150, 50, 6);
        run_phase('{16'd0, 16'd0, 8'd0, 20'hFFFFF, 20'hFFFFF}, 120, 50, 6);
        // Full warm-up count needs a long clean run of anchors.
        run_phase('{16'hFFFF, 16'hFFFF, 8'hFF, 20'd0, 20'd0}, 350, 90, 0);
        run_phase(random_config(), 150, 50, 6);
        run_phase(random_config(), 150, 50, 6);
        calm = 1'b1;
        run_phase(random_config(), 150, 50, 6);

        wait_drained();
        if (sb.expected_q.size() != 0)
            sb.note_error($sformatf("%0d result words never arrived", sb.expected_q.size()));
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
